// ----- rtl/bth_pkg.sv -----
package bth_pkg;

    localparam int HEAP_WORDS   = 2048;
    localparam int HEADER_WORDS = 1;
    localparam int AW           = $clog2(HEAP_WORDS);

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ZERO    = 2'd1;
    localparam logic [1:0] ST_NOSPACE = 2'd2;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [11:0] request_size;
        logic [10:0] block_address;
    } bth_req_t;

    typedef struct packed {
        logic [10:0] granted_address;
        logic [1:0]  status;
    } bth_rsp_t;

    typedef struct packed {
        logic          free_flag;
        logic [AW-1:0] prev_size;
        logic [AW-1:0] own_size;
    } bth_tag_t;

    typedef enum logic [4:0] {
        S_INIT0, S_INIT1, S_INIT2, S_IDLE,
        S_WRD, S_WCHK,
        S_A_WP, S_A_WN, S_A_RM, S_A_M, S_A_RNN, S_A_FIN,
        S_F_RC, S_F_RN, S_F_RQ, S_F_DEC, S_F_RX, S_F_FIN,
        S_DONE
    } bth_state_t;

endpackage

// ----- rtl/boundary_tag_heap_allocator.sv -----
// A zero-size request returns ST_ZERO; allocate walks the tags to the first free block with room
// for the request and a split tag, splits it and merges the remainder with a free next block;
// no space when the walk ends; free merges the block with a free neighbor on either side.
// One beat at a time, busy high while working; at most one tag memory access per cycle.
// After reset the states S_INIT0, S_INIT1 and S_INIT2 write the initial tags with busy high.
// Each result shows for one cycle on done; the receiver cannot stall.
module boundary_tag_heap_allocator
    import bth_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  bth_req_t req,
    output logic     busy,
    output logic     done,
    output bth_rsp_t rsp
);

    localparam logic [AW-1:0] H     = AW'(HEADER_WORDS);
    localparam logic [AW-1:0] LAST  = AW'(HEAP_WORDS - HEADER_WORDS);
    localparam logic [AW-1:0] FIRST = AW'(HEADER_WORDS);
    localparam logic [AW-1:0] ISIZE = AW'(HEAP_WORDS - 3 * HEADER_WORDS);
    localparam logic [AW:0]   HMAX  = (AW+1)'(HEAP_WORDS);

    bth_tag_t mem [HEAP_WORDS];
    bth_tag_t rd_reg;

    bth_state_t state_reg, state_next;
    logic [AW-1:0] p_reg, p_next, n_reg, n_next, q_reg, q_next, m_reg, m_next;
    logic [AW-1:0] req_reg, req_next, sz_reg, sz_next, t_reg, t_next, walk_reg, walk_next;
    logic [AW:0]   steps_reg, steps_next;
    logic          nf_reg, nf_next;
    logic [1:0]    cs_reg, cs_next;
    bth_tag_t      tn_reg, tn_next;
    bth_rsp_t      rsp_reg, rsp_next;
    logic          done_reg, done_next;

    logic          we, re;
    logic [AW-1:0] wa, ra;
    bth_tag_t      wd;
    logic [AW-1:0] cur_next;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (re)
        begin
            rd_reg <= mem[ra];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT0;
            steps_reg <= '0;
            walk_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            steps_reg <= steps_next;
            walk_reg  <= walk_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg   <= p_next;
        n_reg   <= n_next;
        q_reg   <= q_next;
        m_reg   <= m_next;
        req_reg <= req_next;
        sz_reg  <= sz_next;
        t_reg   <= t_next;
        nf_reg  <= nf_next;
        cs_reg  <= cs_next;
        tn_reg  <= tn_next;
        rsp_reg <= rsp_next;
    end

    assign cur_next = p_reg + rd_reg.own_size + H;

    always_comb
    begin
        state_next = state_reg;
        p_next = p_reg; n_next = n_reg; q_next = q_reg; m_next = m_reg;
        req_next = req_reg; sz_next = sz_reg; t_next = t_reg;
        steps_next = steps_reg; walk_next = walk_reg;
        nf_next = nf_reg; cs_next = cs_reg; tn_next = tn_reg;
        rsp_next = rsp_reg; done_next = 1'b0;
        we = 1'b0; re = 1'b0; wa = '0; ra = '0; wd = '0;
        unique case (state_reg)
            S_INIT0:
            begin
                we = 1'b1; wa = '0; wd = '{1'b0, '0, '0};
                state_next = S_INIT1;
            end
            S_INIT1:
            begin
                we = 1'b1; wa = FIRST; wd = '{1'b1, '0, ISIZE};
                state_next = S_INIT2;
            end
            S_INIT2:
            begin
                we = 1'b1; wa = LAST; wd = '{1'b0, ISIZE, '0};
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    req_next = req.request_size[AW-1:0];
                    rsp_next = '0;
                    if (req.mode == MODE_ALLOC)
                    begin
                        if (req.request_size == '0)
                        begin
                            rsp_next.status = ST_ZERO;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            p_next = FIRST;
                            steps_next = '0;
                            // request above the word range can never fit
                            sz_next = (req.request_size[11:AW] != '0) ? '1 : '0;
                            state_next = S_WRD;
                        end
                    end
                    else
                    begin
                        p_next = req.block_address[AW-1:0] - H;
                        state_next = S_F_RC;
                    end
                end
            end
            S_WRD:
            begin
                if (p_reg == LAST || steps_reg >= HMAX)
                begin
                    walk_next = p_reg;
                    rsp_next.status = ST_NOSPACE;
                    state_next = S_DONE;
                end
                else
                begin
                    re = 1'b1; ra = p_reg;
                    state_next = S_WCHK;
                end
            end
            S_WCHK:
            begin
                if (rd_reg.free_flag && sz_reg == '0 &&
                    {1'b0, rd_reg.own_size} > {1'b0, req_reg} + {1'b0, H})
                begin
                    walk_next = p_reg;
                    t_next = rd_reg.own_size;
                    tn_next = rd_reg;
                    state_next = S_A_WP;
                end
                else
                begin
                    p_next = cur_next;
                    steps_next = steps_reg + 1'b1;
                    state_next = S_WRD;
                end
            end
            S_A_WP:
            begin
                we = 1'b1; wa = p_reg; wd = '{1'b0, tn_reg.prev_size, req_reg};
                n_next = p_reg + req_reg + H;
                state_next = S_A_WN;
            end
            S_A_WN:
            begin
                sz_next = t_reg - req_reg - H;
                we = 1'b1; wa = n_reg; wd = '{1'b1, req_reg, t_reg - req_reg - H};
                m_next = n_reg + (t_reg - req_reg - H) + H;
                state_next = S_A_RM;
            end
            S_A_RM:
            begin
                re = 1'b1; ra = m_reg;
                state_next = S_A_M;
            end
            S_A_M:
            begin
                if (rd_reg.free_flag)
                begin
                    sz_next = sz_reg + H + rd_reg.own_size;
                    we = 1'b1; wa = n_reg;
                    wd = '{1'b1, req_reg, sz_reg + H + rd_reg.own_size};
                    m_next = n_reg + sz_reg + H + rd_reg.own_size + H;
                    state_next = S_A_RNN;
                end
                else
                begin
                    we = 1'b1; wa = m_reg; wd = '{rd_reg.free_flag, sz_reg, rd_reg.own_size};
                    state_next = S_A_FIN;
                end
            end
            S_A_RNN:
            begin
                re = 1'b1; ra = m_reg;
                cs_next = 2'd0;
                state_next = S_F_RX;
            end
            S_A_FIN:
            begin
                rsp_next.granted_address = p_reg + H;
                rsp_next.status = ST_OK;
                state_next = S_DONE;
            end
            S_F_RC:
            begin
                re = 1'b1; ra = p_reg;
                state_next = S_F_RN;
            end
            S_F_RN:
            begin
                tn_next = rd_reg;
                n_next = cur_next;
                q_next = p_reg - rd_reg.prev_size - H;
                re = 1'b1; ra = cur_next;
                state_next = S_F_RQ;
            end
            S_F_RQ:
            begin
                nf_next = rd_reg.free_flag;
                t_next = rd_reg.own_size;
                re = 1'b1; ra = q_reg;
                state_next = S_F_DEC;
            end
            S_F_DEC:
            begin
                cs_next = 2'd1;
                if (nf_reg && rd_reg.free_flag)
                begin
                    sz_next = rd_reg.own_size + H + H + tn_reg.own_size + t_reg;
                    we = 1'b1; wa = q_reg;
                    wd = '{rd_reg.free_flag, rd_reg.prev_size, sz_next};
                    m_next = q_reg + sz_next + H;
                    state_next = S_F_RX;
                    re = 1'b0;
                end
                else if (nf_reg)
                begin
                    sz_next = tn_reg.own_size + H + t_reg;
                    we = 1'b1; wa = p_reg;
                    wd = '{1'b1, tn_reg.prev_size, sz_next};
                    m_next = p_reg + sz_next + H;
                    state_next = S_F_RX;
                end
                else if (rd_reg.free_flag)
                begin
                    sz_next = rd_reg.own_size + H + tn_reg.own_size;
                    we = 1'b1; wa = q_reg;
                    wd = '{rd_reg.free_flag, rd_reg.prev_size, sz_next};
                    m_next = n_reg;
                    state_next = S_F_RX;
                end
                else
                begin
                    we = 1'b1; wa = p_reg;
                    wd = '{1'b1, tn_reg.prev_size, tn_reg.own_size};
                    rsp_next = '0;
                    state_next = S_DONE;
                end
            end
            S_F_RX:
            begin
                if (cs_reg == 2'd1)
                begin
                    re = 1'b1; ra = m_reg;
                    cs_next = 2'd2;
                end
                else
                begin
                    we = 1'b1; wa = m_reg; wd = '{rd_reg.free_flag, sz_reg, rd_reg.own_size};
                    if (cs_reg == 2'd0)
                    begin
                        state_next = S_A_FIN;
                    end
                    else
                    begin
                        rsp_next = '0;
                        state_next = S_DONE;
                    end
                end
            end
            S_F_FIN:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                done_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        // a write and a read of the same entry in one cycle: read-before-write is not used
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

// ----- rtl/bth_checker.sv -----
module bth_checker
    import bth_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     start,
    input logic     busy,
    input logic     done,
    input bth_rsp_t rsp
);

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done held");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("done while busy");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("no busy after start");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (rsp.status == ST_OK || rsp.status == ST_ZERO || rsp.status == ST_NOSPACE))
        else $error("bad status");

    a_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status != ST_OK) |-> (rsp.granted_address == '0))
        else $error("address on error");

endmodule

bind boundary_tag_heap_allocator bth_checker u_bth_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done), .rsp(rsp)
);
